// ----- rtl/core/lut_bilinear_interp_2d_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear lookup block
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LUT_BILINEAR_INTERP_2D_DEFINES_SVH
`define LUT_BILINEAR_INTERP_2D_DEFINES_SVH
`ifndef ASSERT_OFF
`define LBI_ASSERT(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
`define LBI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LBI_ASSERT(lbl, ck, rn, cond, msg)
`define LBI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ----- rtl/core/lbi_pkg.sv -----
// ----------------------------------------------------------------------------
// lbi_pkg
// Shared types and constants of the bilinear lookup block.
// ----------------------------------------------------------------------------
package lbi_pkg;

	// register indexes
	localparam logic [2:0] REG_X_MIN        = 3'd0;
	localparam logic [2:0] REG_X_STEP_RECIP = 3'd1;
	localparam logic [2:0] REG_X_LAST_INDEX = 3'd2;
	localparam logic [2:0] REG_Y_MIN        = 3'd3;
	localparam logic [2:0] REG_Y_STEP_RECIP = 3'd4;
	localparam logic [2:0] REG_Y_LAST_INDEX = 3'd5;
	localparam logic [2:0] REG_SCALE        = 3'd6;

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 8;

	typedef struct packed {
		logic signed [31:0] x_min;
		logic        [31:0] x_step_recip;
		logic        [3:0]  x_last_index;
		logic signed [31:0] y_min;
		logic        [31:0] y_step_recip;
		logic        [3:0]  y_last_index;
		logic signed [31:0] scale;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  idx1;
		logic [3:0]  idx2;
		logic [15:0] frac;
	} axis_t;

	// one command word passed from front to back
	typedef struct packed {
		logic               op;
		logic [15:0]        waddr;
		logic signed [15:0] wval;
		logic [3:0][15:0]   raddr;
		logic [15:0]        fx;
		logic [15:0]        fy;
	} cmd_t;

endpackage

// ----- rtl/core/lbi_queue.sv -----
// ----------------------------------------------------------------------------
// lbi_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "lut_bilinear_interp_2d_defines.svh"
module lbi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lbi_pkg::cmd_t push_data,
	input  logic          pop,
	output lbi_pkg::cmd_t pop_data,
	output logic          empty
);
	localparam int D  = lbi_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	lbi_pkg::cmd_t mem_q [D];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign empty    = (count_q == '0);

	`LBI_ASSERT(a_no_overflow, clk, arst_n, !(push && !pop && count_q == CW'(D)), "queue overflow")
	`LBI_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "queue underflow")
	`LBI_ASSERT_NEXT(a_fill_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "count slip")
endmodule

// ----- rtl/core/lbi_front.sv -----
// ----------------------------------------------------------------------------
// lbi_front
// Accepts items, maps coordinates to table addresses and fractions.
// ----------------------------------------------------------------------------
module lbi_front #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16,
	parameter int TABLE_DEPTH  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbi_pkg::cfg_t      cfg,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               operation,
	input  logic [7:0]         entry_address,
	input  logic signed [15:0] entry_value,
	input  logic signed [31:0] x_input,
	input  logic signed [31:0] y_input,
	input  logic               pop,
	output logic               push,
	output lbi_pkg::cmd_t      push_data
);
	localparam int D  = lbi_pkg::QUEUE_DEPTH;
	localparam int CW = $clog2(D + 1);
	localparam logic [3:0] X_LIM = (MAX_X_POINTS - 1 > 15) ? 4'd15 : 4'(MAX_X_POINTS - 1);
	localparam logic [3:0] Y_LIM = (MAX_Y_POINTS - 1 > 15) ? 4'd15 : 4'(MAX_Y_POINTS - 1);

	logic [CW-1:0] credit_q;
	logic          accept;

	logic               v_s1, op_s1;
	logic [15:0]        waddr_s1;
	logic signed [15:0] wval_s1;
	logic signed [32:0] dx_s1, dy_s1;

	logic               v_s2, op_s2, negx_s2, negy_s2;
	logic [15:0]        waddr_s2;
	logic signed [15:0] wval_s2;
	logic [63:0]        px_s2, py_s2;

	logic [15:0] mod_lut [256];
	logic [3:0]  xlast, ylast;
	logic [4:0]  row;
	lbi_pkg::axis_t ax, ay;
	logic [8:0]  a11, a21, a12, a22;

	// address reduction table, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign mod_lut[g] = 16'(g % TABLE_DEPTH);
	end

	// reserve a queue slot for every accepted word
	assign req_stall = (credit_q == CW'(D));
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (!accept && pop) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// stage 1: origin offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= operation;
		waddr_s1 <= mod_lut[entry_address];
		wval_s1  <= entry_value;
		dx_s1    <= 33'(x_input) - 33'(cfg.x_min);
		dy_s1    <= 33'(y_input) - 33'(cfg.y_min);
	end

	// stage 2: scale by reciprocal step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2    <= op_s1;
		waddr_s2 <= waddr_s1;
		wval_s2  <= wval_s1;
		negx_s2  <= dx_s1[32];
		negy_s2  <= dy_s1[32];
		px_s2    <= dx_s1[31:0] * cfg.x_step_recip;
		py_s2    <= dy_s1[31:0] * cfg.y_step_recip;
	end

	function automatic lbi_pkg::axis_t map_axis(logic neg, logic [63:0] p, logic [3:0] last);
		lbi_pkg::axis_t r;
		r = '0;
		if (!neg) begin
			if (p[63:32] >= {28'd0, last}) begin
				r.idx1 = last;
				r.idx2 = last;
			end else begin
				r.idx1 = p[35:32];
				r.idx2 = p[35:32] + 1'b1;
				r.frac = p[31:16];
			end
		end
		return r;
	endfunction

	// stage 3: clamp, form the four row-major addresses
	assign xlast = (cfg.x_last_index > X_LIM) ? X_LIM : cfg.x_last_index;
	assign ylast = (cfg.y_last_index > Y_LIM) ? Y_LIM : cfg.y_last_index;
	assign row   = {1'b0, xlast} + 5'd1;
	assign ax    = map_axis(negx_s2, px_s2, xlast);
	assign ay    = map_axis(negy_s2, py_s2, ylast);
	assign a11   = {5'd0, ay.idx1} * {4'd0, row} + {5'd0, ax.idx1};
	assign a21   = {5'd0, ay.idx1} * {4'd0, row} + {5'd0, ax.idx2};
	assign a12   = {5'd0, ay.idx2} * {4'd0, row} + {5'd0, ax.idx1};
	assign a22   = {5'd0, ay.idx2} * {4'd0, row} + {5'd0, ax.idx2};

	always_comb begin
		push_data.op       = op_s2;
		push_data.waddr    = waddr_s2;
		push_data.wval     = wval_s2;
		push_data.raddr[0] = mod_lut[a11[7:0]];
		push_data.raddr[1] = mod_lut[a21[7:0]];
		push_data.raddr[2] = mod_lut[a12[7:0]];
		push_data.raddr[3] = mod_lut[a22[7:0]];
		push_data.fx       = ax.frac;
		push_data.fy       = ay.frac;
	end

	assign push = v_s2;
endmodule

// ----- rtl/core/lbi_back.sv -----
// ----------------------------------------------------------------------------
// lbi_back
// Holds the sample table, executes writes and interpolating lookups.
// ----------------------------------------------------------------------------
module lbi_back #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] scale,
	input  logic               empty,
	input  lbi_pkg::cmd_t      cmd,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [47:0] result_value
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// one copy of the table per neighbour, each with its own read port
	logic [15:0] mem [4][TABLE_DEPTH];

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5_q;
	logic signed [15:0] rd_s1 [4];
	logic [15:0]        fx_s1, fy_s1, fy_s2;
	logic signed [31:0] z1_s2, z2_s2;
	logic signed [47:0] z_s3;
	logic signed [63:0] p_s4;
	logic signed [47:0] res_q;

	logic signed [16:0] d1, d2, fxs, fys;
	logic signed [33:0] t1, t2, z1_w, z2_w;
	logic signed [32:0] dz;
	logic signed [49:0] t3, z_w;

	// advance whenever the output register is free
	assign en  = !(v_s5_q && rsp_stall);
	assign pop = en && !empty;

	// table writes and registered reads
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (pop && cmd.op == lbi_pkg::OP_WRITE) mem[k][cmd.waddr[AW-1:0]] <= cmd.wval;
			if (en) rd_s1[k] <= mem[k][cmd.raddr[k][AW-1:0]];
		end
	end

	// blend along x
	assign fxs  = $signed({1'b0, fx_s1});
	assign d1   = $signed({rd_s1[1][15], rd_s1[1]}) - $signed({rd_s1[0][15], rd_s1[0]});
	assign d2   = $signed({rd_s1[3][15], rd_s1[3]}) - $signed({rd_s1[2][15], rd_s1[2]});
	assign t1   = d1 * fxs;
	assign t2   = d2 * fxs;
	assign z1_w = 34'($signed({rd_s1[0], 16'h0000})) + t1;
	assign z2_w = 34'($signed({rd_s1[2], 16'h0000})) + t2;

	// blend along y
	assign fys = $signed({1'b0, fy_s2});
	assign dz  = 33'(z2_s2) - 33'(z1_s2);
	assign t3  = dz * fys;
	assign z_w = 50'($signed({z1_s2, 16'h0000})) + t3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5_q <= 1'b0;
		end else if (en) begin
			v_s1   <= pop && cmd.op == lbi_pkg::OP_LOOKUP;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5_q <= v_s4;
		end
	end

	// hold payload while the output is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= cmd.fx;
			fy_s1 <= cmd.fy;
			fy_s2 <= fy_s1;
			z1_s2 <= z1_w[31:0];
			z2_s2 <= z2_w[31:0];
			z_s3  <= z_w[47:0];
			p_s4  <= $signed(z_s3[47:16]) * scale;
			res_q <= p_s4[63:16];
		end
	end

	assign rsp_valid    = v_s5_q;
	assign result_value = res_q;
endmodule

// ----- rtl/core/lut_bilinear_interp_2d.sv -----
// ----------------------------------------------------------------------------
// lut_bilinear_interp_2d
// Two-dimensional bilinear lookup table with scaled Q32.16 output.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall): operation selects a table write
// (entry_address, entry_value) or a lookup (x_input, y_input). A word moves
// when req_valid is high and req_stall low. Writes give no response.
// Response channel (rsp_valid / rsp_stall): one result_value per lookup, in
// request order, 48 bits signed with 16 fraction bits.
// Throughput: one request per cycle while req_stall is low. A request passes
// two front stages, the address stage that writes the queue, then table
// read, x blend, y blend, scale multiply and the output register.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while idle. An unknown index is ignored.
// Reset: registers take their reset values, queue and pipelines empty; the
// sample table holds nothing until written and needs no clearing pass.
// Receiver stall: the back end holds; the front keeps taking requests until
// the eight-word queue is reserved, then asserts req_stall.
// ----------------------------------------------------------------------------
module lut_bilinear_interp_2d #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16,
	parameter int TABLE_DEPTH  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               operation,
	input  logic [7:0]         entry_address,
	input  logic signed [15:0] entry_value,
	input  logic signed [31:0] x_input,
	input  logic signed [31:0] y_input,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [47:0] result_value
);
	lbi_pkg::cfg_t cfg_q;
	lbi_pkg::cmd_t push_data, pop_data;
	logic          push, pop, empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min        <= '0;
			cfg_q.x_step_recip <= 32'd65536;
			cfg_q.x_last_index <= 4'd1;
			cfg_q.y_min        <= '0;
			cfg_q.y_step_recip <= 32'd65536;
			cfg_q.y_last_index <= 4'd1;
			cfg_q.scale        <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbi_pkg::REG_X_MIN:        cfg_q.x_min        <= cfg_data;
				lbi_pkg::REG_X_STEP_RECIP: cfg_q.x_step_recip <= cfg_data;
				lbi_pkg::REG_X_LAST_INDEX: cfg_q.x_last_index <= cfg_data[3:0];
				lbi_pkg::REG_Y_MIN:        cfg_q.y_min        <= cfg_data;
				lbi_pkg::REG_Y_STEP_RECIP: cfg_q.y_step_recip <= cfg_data;
				lbi_pkg::REG_Y_LAST_INDEX: cfg_q.y_last_index <= cfg_data[3:0];
				lbi_pkg::REG_SCALE:        cfg_q.scale        <= cfg_data;
				default: ;
			endcase
		end
	end

	lbi_front #(
		.MAX_X_POINTS(MAX_X_POINTS),
		.MAX_Y_POINTS(MAX_Y_POINTS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.entry_address(entry_address),
		.entry_value  (entry_value),
		.x_input      (x_input),
		.y_input      (y_input),
		.pop          (pop),
		.push         (push),
		.push_data    (push_data)
	);

	lbi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	lbi_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.scale       (cfg_q.scale),
		.empty       (empty),
		.cmd         (pop_data),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_value(result_value)
	);
endmodule
